// ===== sv/integer_alu_with_flags_unit_macros.svh =====
// Assertion macros for the integer ALU with flags.
`ifndef INTEGER_ALU_WITH_FLAGS_UNIT_MACROS_SVH
`define INTEGER_ALU_WITH_FLAGS_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IAF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define IAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/iaf_pkg.sv =====
// Package with opcodes, flag positions, error codes and shared types.
`timescale 1ns / 1ps
package iaf_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned CntW = 7;

  localparam logic [5:0] OpCmpr = 6'h1e;
  localparam logic [5:0] OpCmpi = 6'h1f;
  localparam logic [5:0] OpAdd  = 6'h20;
  localparam logic [5:0] OpSub  = 6'h22;
  localparam logic [5:0] OpImul = 6'h24;
  localparam logic [5:0] OpIdiv = 6'h26;
  localparam logic [5:0] OpUmul = 6'h28;
  localparam logic [5:0] OpUdiv = 6'h2a;
  localparam logic [5:0] OpRem  = 6'h2c;
  localparam logic [5:0] OpMod  = 6'h2e;
  localparam logic [5:0] OpAnd  = 6'h30;
  localparam logic [5:0] OpOr   = 6'h32;
  localparam logic [5:0] OpNor  = 6'h34;
  localparam logic [5:0] OpXor  = 6'h36;
  localparam logic [5:0] OpShl  = 6'h38;
  localparam logic [5:0] OpAsr  = 6'h3a;
  localparam logic [5:0] OpLsr  = 6'h3c;
  localparam logic [5:0] OpBit  = 6'h3e;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrDivZero = 2'd1;
  localparam logic [1:0] ErrInvalid = 2'd2;

  localparam int unsigned FlEq = 0;
  localparam int unsigned FlLt = 1;
  localparam int unsigned FlLtu = 2;
  localparam int unsigned FlSign = 3;
  localparam int unsigned FlZero = 4;
  localparam int unsigned FlCu = 5;
  localparam int unsigned FlCs = 6;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [63:0] first_value;
    logic [63:0] second_value;
    logic [15:0] immediate;
    logic [1:0]  compare_order;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        writes_register;
    logic [6:0]  flags_out;
    logic [1:0]  error_code;
  } out_item_t;

  // Control and status of the serial datapath.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } seq_ctl_t;
endpackage

// ===== sv/iaf_if.sv =====
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
`default_nettype none
interface iaf_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/iaf_serial.sv =====
// Bit-serial engine: add/sub/compare, shift-add multiply, restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module iaf_serial (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  mode,    // 0 add/sub, 1 mul, 2 div
  input  wire logic        sub,
  input  wire logic [63:0] opa,
  input  wire logic [63:0] opb,
  output iaf_pkg::seq_ctl_t ctl,
  output logic [63:0]      res_lo,  // sum, product or quotient
  output logic [63:0]      res_hi,  // remainder
  output logic             cout     // carry out of add, no-borrow for sub
);
  logic [63:0] a, b, acc, rem;
  logic [iaf_pkg::CntW-1:0] cnt;
  logic c, busy, done;
  logic [64:0] trial;
  logic        sb;

  assign ctl = '{start: start, busy: busy, done: done};
  assign res_lo = acc;
  assign res_hi = rem;
  assign cout = c;
  assign sb = sub ? ~b[0] : b[0];
  assign trial = {rem[62:0], a[63]} - {1'b0, b} + 65'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        a <= opa;
        b <= opb;
        acc <= '0;
        rem <= '0;
        c <= sub;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == iaf_pkg::CntW'(63)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        unique case (mode)
          2'd0: begin
            // one sum bit per cycle, LSB first
            acc <= {a[0] ^ sb ^ c, acc[63:1]};
            c <= (a[0] & sb) | (a[0] & c) | (sb & c);
            a <= a >> 1;
            b <= b >> 1;
          end
          2'd1: begin
            // low product: add shifted multiplicand per multiplier bit
            if (b[0]) acc <= acc + a;
            a <= a << 1;
            b <= b >> 1;
          end
          default: begin
            if (!trial[64] || rem[63]) begin
              rem <= trial[63:0];
              acc <= {acc[62:0], 1'b1};
            end else begin
              rem <= {rem[62:0], a[63]};
              acc <= {acc[62:0], 1'b0};
            end
            a <= a << 1;
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/integer_alu_with_flags_unit.sv =====
// Top level: 64-bit integer ALU with condition flags.
// channel | dir | payload
// in_ch   | in  | opcode, first_value, second_value, immediate, compare_order
// out_ch  | out | result_value, writes_register, flags_out, error_code
// Arithmetic, compares, multiply and divide pass from the input transfer through the serial
// engine, one bit per cycle, to a valid result. Logic, shifts and errors skip the engine.
// A final fixup state (S_FIN) applies signs and carries. The next input transfer
// is taken the cycle after the result transfer. rst clears the flags and control;
// a stalled result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_alu_with_flags_unit_macros.svh"
module integer_alu_with_flags_unit (
  input wire logic clk,
  input wire logic rst,
  iaf_if.sink   in_ch,
  iaf_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  iaf_pkg::in_item_t it;
  iaf_pkg::in_item_t cur;
  iaf_pkg::out_item_t ores;
  logic [6:0] flags;
  logic [5:0] op;
  logic [63:0] x, y, bs, bz, sx, sy;
  logic [1:0] mode;
  logic sub, start, neg_q, neg_r, cout;
  logic [63:0] lo, hi;
  iaf_pkg::seq_ctl_t ctl;

  // decode the live input while idle, the captured item afterwards
  assign cur = (state == S_IDLE) ? in_ch.payload : it;

  assign op = cur.opcode;
  assign bs = op[0] ? {{48{cur.immediate[15]}}, cur.immediate} : cur.second_value;
  assign bz = op[0] ? {48'd0, cur.immediate} : cur.second_value;

  // compare operands
  always_comb begin
    x = cur.first_value;
    y = (op == iaf_pkg::OpCmpi) ? bs : cur.second_value;
    if (op == iaf_pkg::OpCmpi && cur.compare_order == 2'd1) begin
      x = bs;
      y = cur.first_value;
    end
  end

  logic is_div, is_signed_div;
  assign is_div = ({op[5:1], 1'b0} == iaf_pkg::OpIdiv) || ({op[5:1], 1'b0} == iaf_pkg::OpUdiv)
    || ({op[5:1], 1'b0} == iaf_pkg::OpRem) || ({op[5:1], 1'b0} == iaf_pkg::OpMod);
  assign is_signed_div = is_div && ({op[5:1], 1'b0} != iaf_pkg::OpUdiv);
  assign sx = (is_signed_div && cur.first_value[63]) ? -cur.first_value : cur.first_value;
  assign sy = (is_signed_div && bs[63]) ? -bs : bs;

  always_comb begin
    mode = 2'd0;
    sub = 1'b1;
    if (op == iaf_pkg::OpCmpr || op == iaf_pkg::OpCmpi) begin
      mode = 2'd0;
    end else if ({op[5:1], 1'b0} == iaf_pkg::OpAdd) begin
      sub = 1'b0;
    end else if ({op[5:1], 1'b0} == iaf_pkg::OpImul || {op[5:1], 1'b0} == iaf_pkg::OpUmul) begin
      mode = 2'd1;
    end else if (is_div) begin
      mode = 2'd2;
    end
  end

  logic [63:0] opa_s, opb_s;
  assign opa_s = (mode == 2'd2) ? sx : ((op == iaf_pkg::OpCmpr || op == iaf_pkg::OpCmpi) ? x
    : cur.first_value);
  assign opb_s = (mode == 2'd2) ? sy : ((op == iaf_pkg::OpCmpr || op == iaf_pkg::OpCmpi) ? y
    : bs);

  iaf_serial u_ser (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .sub(sub),
    .opa(opa_s), .opb(opb_s), .ctl(ctl), .res_lo(lo), .res_hi(hi), .cout(cout)
  );

  logic needs_ser, bad;
  assign bad = (op < iaf_pkg::OpCmpr) || (op == iaf_pkg::OpCmpi && cur.compare_order[1]);
  assign needs_ser = !bad && (op < iaf_pkg::OpAnd) && !(is_div && bs == '0);
  assign start = (state == S_IDLE) && in_ch.valid && needs_ser;
  assign neg_q = cur.first_value[63] ^ bs[63];
  assign neg_r = cur.first_value[63];

  // quick ops and final fixup
  logic [5:0] sh;
  logic [63:0] q, r, m, s1;
  logic cu, cs, s1c, u, v1, v2;
  iaf_pkg::out_item_t fin;
  always_comb begin
    sh = bz[5:0];
    cu = flags[iaf_pkg::FlCu];
    cs = flags[iaf_pkg::FlCs];
    q = neg_q ? -lo : lo;
    r = neg_r ? -hi : hi;
    m = r;
    s1 = lo;
    s1c = cout;
    u = 1'b0; v1 = 1'b0; v2 = 1'b0;
    fin = '{result_value: '0, writes_register: 1'b0, flags_out: flags,
            error_code: iaf_pkg::ErrNone};
    if (bad) begin
      fin.error_code = iaf_pkg::ErrInvalid;
    end else if (op == iaf_pkg::OpCmpr || op == iaf_pkg::OpCmpi) begin
      fin.flags_out[iaf_pkg::FlEq] = (x == y);
      fin.flags_out[iaf_pkg::FlLtu] = !cout;
      fin.flags_out[iaf_pkg::FlLt] = (x[63] ^ y[63]) ? x[63] : !cout;
      fin.flags_out[iaf_pkg::FlSign] = x[63];
      fin.flags_out[iaf_pkg::FlZero] = (x == '0);
    end else if (is_div && bs == '0) begin
      fin.error_code = iaf_pkg::ErrDivZero;
    end else begin
      fin.writes_register = 1'b1;
      case ({op[5:1], 1'b0})
        iaf_pkg::OpAdd: begin
          u = s1c || (cu && (s1 == '1));
          v1 = (cur.first_value[63] == bs[63]) && (s1[63] != bs[63]);
          v2 = cs && (s1 == 64'h7fff_ffff_ffff_ffff);
          fin.result_value = s1 + {63'd0, cs};
          fin.flags_out[iaf_pkg::FlCu] = u;
          fin.flags_out[iaf_pkg::FlCs] = v1 || v2;
        end
        iaf_pkg::OpSub: begin
          u = !s1c || (cu && (s1 == '0));
          v1 = (cur.first_value[63] != bs[63]) && (s1[63] != cur.first_value[63]);
          v2 = cs && (s1 == 64'h8000_0000_0000_0000);
          fin.result_value = s1 - {63'd0, cs};
          fin.flags_out[iaf_pkg::FlCu] = u;
          fin.flags_out[iaf_pkg::FlCs] = v1 || v2;
        end
        iaf_pkg::OpImul, iaf_pkg::OpUmul: fin.result_value = lo;
        iaf_pkg::OpIdiv: fin.result_value = q;
        iaf_pkg::OpUdiv: fin.result_value = lo;
        iaf_pkg::OpRem: fin.result_value = r;
        iaf_pkg::OpMod: begin
          if (r[63]) m = bs[63] ? r - bs : r + bs;
          fin.result_value = (bs == '1) ? '0 : m;
        end
        iaf_pkg::OpAnd: fin.result_value = cur.first_value & bz;
        iaf_pkg::OpOr: fin.result_value = cur.first_value | bz;
        iaf_pkg::OpNor: fin.result_value = ~(cur.first_value | bz);
        iaf_pkg::OpXor: fin.result_value = cur.first_value ^ bz;
        iaf_pkg::OpShl: fin.result_value = cur.first_value << sh;
        iaf_pkg::OpAsr: fin.result_value = $signed(cur.first_value) >>> sh;
        iaf_pkg::OpLsr: fin.result_value = cur.first_value >> sh;
        default: fin.result_value = {63'd0, cur.first_value[sh]};
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_ch.valid) state_next = needs_ser ? S_RUN : S_FIN;
      S_RUN: if (ctl.done) state_next = S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // hold input in S_IDLE only; capture on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      flags <= '0;
    end else begin
      state <= state_next;
      if (state == S_FIN) flags <= fin.flags_out;
    end
    if (state == S_IDLE && in_ch.valid) it <= in_ch.payload;
    if (state == S_FIN) ores <= fin;
  end

  // serial start uses the live input, so latch-time start matches capture
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload = ores;

  `IAF_ASSERT_IMPL(a_out_flags, clk, rst, out_ch.valid, out_ch.payload.flags_out == flags, "flags mismatch")
  `IAF_ASSERT_NEXT(a_done_fin, clk, rst, ctl.done, state == S_FIN, "serial done lost")
  `IAF_ASSERT_IMPL(a_err_nowr, clk, rst, out_ch.valid && out_ch.payload.error_code != iaf_pkg::ErrNone, !out_ch.payload.writes_register, "write on error")
endmodule
`default_nettype wire

// ===== bench/integer_alu_with_flags_unit_chk.sv =====
// Checker: predicts ALU results and flags from the input transfers and compares outputs.
`timescale 1ns / 1ps
module integer_alu_with_flags_unit_chk
  import iaf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  iaf_if.sink  in_mon,
  iaf_if.sink  out_mon,
  output int   fail_count,
  output int   pending
);
  out_item_t results_due[$];
  logic [6:0] flags_q;

  function automatic logic [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed truncating divide; d is nonzero.
  function automatic void sdivide(logic [63:0] n, logic [63:0] d,
                                  output logic [63:0] q, output logic [63:0] r);
    logic [63:0] un, ud, uq, ur;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    uq = un / ud;
    ur = un % ud;
    q = (n[63] != d[63]) ? -uq : uq;
    r = n[63] ? -ur : ur;
  endfunction

  function automatic logic [6:0] compare_flags(logic [6:0] f, logic [63:0] x,
                                               logic [63:0] y);
    logic [6:0] g;
    g = f & ((7'd1 << FlCu) | (7'd1 << FlCs));
    g[FlEq] = (x == y);
    g[FlLt] = ($signed(x) < $signed(y));
    g[FlLtu] = (x < y);
    g[FlSign] = x[63];
    g[FlZero] = (x == 64'd0);
    return g;
  endfunction

  function automatic out_item_t alu_predict(in_item_t it);
    out_item_t o;
    logic [63:0] a, bs, bz, res, q, r, s1, s2, cu, cs;
    logic [5:0] sh;
    logic [1:0] err;
    logic u, v;
    a = it.first_value;
    bs = it.opcode[0] ? sext16(it.immediate) : it.second_value;
    bz = it.opcode[0] ? {48'd0, it.immediate} : it.second_value;
    sh = bz[5:0];
    res = '0;
    err = ErrNone;
    cu = {63'd0, flags_q[FlCu]};
    cs = {63'd0, flags_q[FlCs]};
    if (it.opcode < OpCmpr) begin
      err = ErrInvalid;
    end else if (it.opcode == OpCmpr) begin
      flags_q = compare_flags(flags_q, a, it.second_value);
    end else if (it.opcode == OpCmpi) begin
      if (it.compare_order == 2'd0) flags_q = compare_flags(flags_q, a, sext16(it.immediate));
      else if (it.compare_order == 2'd1)
        flags_q = compare_flags(flags_q, sext16(it.immediate), a);
      else err = ErrInvalid;
    end else begin
      case ({it.opcode[5:1], 1'b0})
        OpAdd: begin
          s1 = a + bs;
          u = (s1 < a) || (s1 + cu < s1);
          s2 = s1 + cs;
          v = 1'(((a ^ s1) & (bs ^ s1)) >> 63 | ((s1 ^ s2) & (cs ^ s2)) >> 63);
          res = s2;
          flags_q[FlCu] = u;
          flags_q[FlCs] = v;
        end
        OpSub: begin
          s1 = a - bs;
          u = (a < bs) || (s1 < cu);
          s2 = s1 - cs;
          v = 1'(((a ^ bs) & (a ^ s1)) >> 63 | ((s1 ^ cs) & (s1 ^ s2)) >> 63);
          res = s2;
          flags_q[FlCu] = u;
          flags_q[FlCs] = v;
        end
        OpImul, OpUmul: res = a * bs;
        OpIdiv: if (bs == 0) err = ErrDivZero; else begin sdivide(a, bs, q, r); res = q; end
        OpUdiv: if (bs == 0) err = ErrDivZero; else res = a / bs;
        OpRem:  if (bs == 0) err = ErrDivZero; else begin sdivide(a, bs, q, r); res = r; end
        OpMod: begin
          if (bs == 0) err = ErrDivZero;
          else if (bs == '1) res = '0;
          else begin
            sdivide(a, bs, q, r);
            if (r[63]) r = bs[63] ? r - bs : r + bs;
            res = r;
          end
        end
        OpAnd: res = a & bz;
        OpOr:  res = a | bz;
        OpNor: res = ~(a | bz);
        OpXor: res = a ^ bz;
        OpShl: res = a << sh;
        OpAsr: res = $unsigned($signed(a) >>> sh);
        OpLsr: res = a >> sh;
        default: res = (a >> sh) & 64'd1;
      endcase
    end
    o.writes_register = (err == ErrNone) && (it.opcode >= OpAdd);
    o.result_value = o.writes_register ? res : '0;
    o.flags_out = flags_q;
    o.error_code = err;
    return o;
  endfunction

  assign pending = results_due.size();

  always @(posedge clk) begin
    out_item_t got, want;
    if (rst) begin
      flags_q = '0;
      results_due.delete();
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) results_due.push_back(alu_predict(in_mon.payload));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected val=%h wr=%b fl=%h err=%0d actual val=%h wr=%b fl=%h err=%0d",
                     $time, want.result_value, want.writes_register, want.flags_out,
                     want.error_code, got.result_value, got.writes_register, got.flags_out,
                     got.error_code);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== bench/integer_alu_with_flags_unit_tb.sv =====
// Testbench top: drives ALU operations with idling phases and reports the verdict.
`timescale 1ns / 1ps
module integer_alu_with_flags_unit_tb;
  import iaf_pkg::*;

  logic clk;
  logic rst;
  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;

  iaf_if #(.payload_t(in_item_t)) in_ch ();
  iaf_if #(.payload_t(out_item_t)) out_ch ();

  integer_alu_with_flags_unit dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  integer_alu_with_flags_unit_chk chk (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge_value();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7fff_ffff_ffff_ffff;
      5: return {$urandom_range(7)} - 64'd3;
      default: return rand64();
    endcase
  endfunction

  // Keep valid high across back-to-back items; drop it only while idling.
  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.payload <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_op(logic [5:0] op, logic [63:0] a, logic [63:0] b,
                         logic [15:0] imm, logic [1:0] ord);
    in_item_t it;
    it.opcode = op;
    it.first_value = a;
    it.second_value = b;
    it.immediate = imm;
    it.compare_order = ord;
    send(it);
  endtask

  task automatic send_random();
    in_item_t it;
    it.opcode = ($urandom_range(19) == 0) ? 6'($urandom_range(OpCmpr - 1))
                                          : 6'($urandom_range(OpBit + 1, OpCmpr));
    it.first_value = edge_value();
    it.second_value = ($urandom_range(9) == 0) ? 64'd0 : edge_value();
    it.immediate = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
    it.compare_order = ($urandom_range(3) == 0) ? 2'($urandom) : 2'($urandom_range(1));
    send(it);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation, field extremes, errors and overflow corners.
    send_op(6'd0, '1, '1, 16'hffff, 2'd3);
    send_op(OpCmpr, 64'd5, 64'd5, 16'd0, 2'd0);
    send_op(OpCmpi, 64'h8000_0000_0000_0000, 64'd0, 16'hffff, 2'd0);
    send_op(OpCmpi, 64'd0, 64'd0, 16'h8000, 2'd1);
    send_op(OpCmpi, 64'd1, 64'd0, 16'd1, 2'd2);
    send_op(OpAdd, '1, 64'd1, 16'd0, 2'd0);
    send_op(OpAdd + 6'd1, 64'h7fff_ffff_ffff_ffff, 64'd0, 16'h0001, 2'd0);
    send_op(OpSub, 64'd0, 64'd1, 16'd0, 2'd0);
    send_op(OpSub + 6'd1, 64'h8000_0000_0000_0000, 64'd0, 16'd1, 2'd0);
    send_op(OpImul, '1, '1, 16'd0, 2'd0);
    send_op(OpUmul + 6'd1, 64'd3, 64'd0, 16'hffff, 2'd0);
    send_op(OpIdiv, 64'h8000_0000_0000_0000, '1, 16'd0, 2'd0);
    send_op(OpIdiv + 6'd1, 64'd7, 64'd0, 16'd0, 2'd0);
    send_op(OpUdiv, '1, 64'd3, 16'd0, 2'd0);
    send_op(OpRem, 64'h8000_0000_0000_0000, '1, 16'd0, 2'd0);
    send_op(OpRem + 6'd1, -64'd7, 64'd0, 16'd2, 2'd0);
    send_op(OpMod, -64'd7, 64'd3, 16'd0, 2'd0);
    send_op(OpMod + 6'd1, -64'd7, 64'd0, 16'hfffd, 2'd0);
    send_op(OpMod, 64'd9, '1, 16'd0, 2'd0);
    send_op(OpAnd + 6'd1, '1, 64'd0, 16'hffff, 2'd0);
    send_op(OpOr, 64'd0, '1, 16'd0, 2'd0);
    send_op(OpNor, 64'd0, 64'd0, 16'd0, 2'd0);
    send_op(OpXor + 6'd1, '1, 64'd0, 16'h8000, 2'd0);
    send_op(OpShl, 64'd1, 64'd127, 16'd0, 2'd0);
    send_op(OpAsr + 6'd1, 64'h8000_0000_0000_0000, 64'd0, 16'hffc3, 2'd0);
    send_op(OpLsr, '1, 64'd63, 16'd0, 2'd0);
    send_op(OpBit + 6'd1, 64'h8000_0000_0000_0000, 64'd0, 16'd63, 2'd0);

    // Random phases with different idle patterns.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 55 : 31) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 55 : 31) : 0;
      for (int n = 0; n < 220; n++) begin
        if (ph == 0 && n == 20) hold_off = 600;
        send_random();
      end
    end

    in_ch.valid <= 1'b0;
    send_idle_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
